### sv/sha2h_pkg.sv
package sha2h_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BLK_DEPTH = 16;
  localparam int unsigned CHN_DEPTH = 8;
  localparam int unsigned TDATA_W = 40;

  typedef struct packed {
    logic       shift;
    logic       round;
    logic       use_blk;
    logic [5:0] rnd;
  } sha2h_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

  function automatic logic [31:0] init_value(input logic mode, input logic [2:0] idx);
    logic [31:0] v;
    if (mode) begin
      unique case (idx)
        3'd0: v = 32'hc1059ed8;
        3'd1: v = 32'h367cd507;
        3'd2: v = 32'h3070dd17;
        3'd3: v = 32'hf70e5939;
        3'd4: v = 32'hffc00b31;
        3'd5: v = 32'h68581511;
        3'd6: v = 32'h64f98fa7;
        default: v = 32'hbefa4fa4;
      endcase
    end else begin
      unique case (idx)
        3'd0: v = 32'h6a09e667;
        3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;
        3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;
        3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
    end
    init_value = v;
  endfunction

endpackage

### sv/sha2h_ram.sv
module sha2h_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sha2h_core.sv
module sha2h_core
  import sha2h_pkg::*;
(
  input  logic        clk_i,
  input  sha2h_ctl_t  ctl_i,
  input  logic [31:0] chain_i,
  input  logic [31:0] blk_i,
  output logic [31:0] wk_a_o
);

  logic [31:0] wk_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_calc;
  logic [31:0] w_cur;
  logic [31:0] sig0;
  logic [31:0] sig1;
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    sig0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sig1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_calc = w_q[0] + sig0 + w_q[9] + sig1;
    w_cur = ctl_i.use_blk ? blk_i : w_calc;
    big1 = rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25);
    ch = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
    t1 = wk_q[7] + big1 + ch + round_k(ctl_i.rnd) + w_cur;
    big0 = rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22);
    maj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
    t2 = big0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      for (int i = 0; i < 7; i++) begin
        wk_q[i] <= wk_q[i + 1];
      end
      wk_q[7] <= chain_i;
    end else if (ctl_i.round) begin
      wk_q[0] <= t1 + t2;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= wk_q[1];
      wk_q[3] <= wk_q[2];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[5] <= wk_q[4];
      wk_q[6] <= wk_q[5];
      wk_q[7] <= wk_q[6];
    end
    if (ctl_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_cur;
    end
  end

  assign wk_a_o = wk_q[0];

endmodule

### sv/sha256_sha224_hash.sv
// Items are taken one per cycle while the hasher is idle; an item that fills a block
// holds the input until that block is done, and the last item of a message until the
// padding blocks and the digest are done. Each full block loads the working registers
// from the chain memory, runs 64 rounds, and adds the result back into the chain memory.
// After the last item, padding fills one or two blocks, and the digest leaves the chain
// memory one word at a time, each word once the sink has taken the one before.
module sha256_sha224_hash
  import sha2h_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // message_word [31:0], valid_bytes [34:32], zero fill above
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // digest_word [31:0], word_index [34:32], zero fill above
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [2:0]  after_q, after_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        mode_q, mode_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [7:0]  vld_q, vld_d;
  logic        rvld_q;
  logic [2:0]  raddr_q;
  logic [3:0]  pidx_q, pidx_d;
  logic        pfirst_q, pfirst_d;
  logic        lhere_q, lhere_d;
  logic        pend_q, pend_d;
  logic        mv_q, mv_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] odata_q;
  logic [2:0]  oidx_q;
  logic        olast_q;

  logic        accept;
  logic [2:0]  cnt_in;
  logic [2:0]  total;
  logic [4:0]  shamt;
  logic [55:0] hmask;
  logic [55:0] merged;
  logic [31:0] pmask;
  logic [31:0] padw;
  logic        wr_word;
  logic        blk_we;
  logic [3:0]  blk_waddr;
  logic [31:0] blk_wdata;
  logic [3:0]  blk_raddr;
  logic [31:0] blk_rdata;
  logic        chn_we;
  logic [31:0] chn_rdata;
  logic [31:0] chn_eff;
  logic [31:0] wk_a;
  logic [3:0]  pcur;
  logic        plen;
  logic [31:0] pdata;
  logic [2:0]  last_idx;
  logic        oload;
  sha2h_ctl_t  ctl;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    cnt_in = s_axis_tdata[34] ? 3'd4 : s_axis_tdata[34:32];
    total = {1'b0, fill_q[1:0]} + cnt_in;
    shamt = {fill_q[1:0], 3'b000};
    hmask = ~({56{1'b1}} >> shamt);
    merged = ({acc_q, 24'h0} & hmask) | (({s_axis_tdata[31:0], 24'h0} >> shamt) & ~hmask);
    wr_word = total[2];
    pmask = ~({32{1'b1}} >> shamt);
    padw = (acc_q & pmask) | (32'h8000_0000 >> shamt);
    pcur = pfirst_q ? fill_q[5:2] : pidx_q;
    plen = pfirst_q ? (fill_q[5:2] <= 4'd13) : lhere_q;
    if (pfirst_q) begin
      pdata = padw;
    end else if (plen && pcur == 4'd14) begin
      pdata = bits_q[63:32];
    end else if (plen && pcur == 4'd15) begin
      pdata = bits_q[31:0];
    end else begin
      pdata = '0;
    end
  end

  assign blk_we = (accept & wr_word) | (state_q == S_PAD);
  assign blk_waddr = (state_q == S_PAD) ? pcur : fill_q[5:2];
  assign blk_wdata = (state_q == S_PAD) ? pdata : merged[55:24];
  assign blk_raddr = (state_q == S_ROUND) ? cnt_q[3:0] + 4'd1 : '0;

  assign chn_we = (state_q == S_UPD) && (cnt_q != 6'd0);
  assign chn_eff = rvld_q ? chn_rdata : init_value(mode_q, raddr_q);
  assign last_idx = mode_q ? 3'd6 : 3'd7;

  always_comb begin
    ctl.shift = ((state_q == S_LOAD) || (state_q == S_UPD)) && (cnt_q != 6'd0);
    ctl.round = (state_q == S_ROUND);
    ctl.use_blk = (cnt_q[5:4] == 2'b00);
    ctl.rnd = cnt_q;
  end

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    cnt_d = cnt_q;
    mode_d = mode_q;
    fill_d = fill_q;
    bits_d = bits_q;
    vld_d = vld_q;
    pidx_d = pidx_q;
    pfirst_d = pfirst_q;
    lhere_d = lhere_q;
    pend_d = pend_q;
    acc_d = acc_q;
    oload = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          fill_d = fill_q + {3'b000, cnt_in};
          bits_d = bits_q + {58'h0, cnt_in, 3'b000};
          acc_d = wr_word ? {merged[23:0], 8'h00} : merged[55:24];
          pfirst_d = 1'b1;
          if (wr_word && fill_q[5:2] == 4'd15) begin
            state_d = S_LOAD;
            cnt_d = '0;
            after_d = s_axis_tlast ? S_PAD : S_IDLE;
          end else if (s_axis_tlast) begin
            state_d = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd8) begin
          state_d = S_ROUND;
          cnt_d = '0;
        end
      end
      S_ROUND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_UPD;
          cnt_d = '0;
        end
      end
      S_UPD: begin
        cnt_d = cnt_q + 6'd1;
        if (chn_we) begin
          vld_d[cnt_q[2:0] - 3'd1] = 1'b1;
        end
        if (cnt_q == 6'd8) begin
          state_d = after_q;
          cnt_d = '0;
        end
      end
      S_PAD: begin
        pfirst_d = 1'b0;
        pidx_d = pcur + 4'd1;
        lhere_d = plen;
        if (pcur == 4'd15) begin
          state_d = S_LOAD;
          cnt_d = '0;
          after_d = plen ? S_OUT : S_PAD;
          lhere_d = 1'b1;
        end
      end
      S_OUT: begin
        if (pend_q) begin
          oload = 1'b1;
          pend_d = 1'b0;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q[2:0] == last_idx) begin
            state_d = S_IDLE;
            cnt_d = '0;
            vld_d = '0;
            fill_d = '0;
            bits_d = '0;
          end
        end else if (!mv_q || m_axis_tready) begin
          pend_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      vld_d = '0;
      fill_d = '0;
      bits_d = '0;
    end
    mv_d = (mv_q & ~m_axis_tready) | oload;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= S_IDLE;
      cnt_q <= '0;
      mode_q <= 1'b0;
      fill_q <= '0;
      bits_q <= '0;
      vld_q <= '0;
      rvld_q <= 1'b0;
      raddr_q <= '0;
      pidx_q <= '0;
      pfirst_q <= 1'b0;
      lhere_q <= 1'b0;
      pend_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      cnt_q <= cnt_d;
      mode_q <= mode_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      vld_q <= vld_d;
      rvld_q <= vld_q[cnt_q[2:0]];
      raddr_q <= cnt_q[2:0];
      pidx_q <= pidx_d;
      pfirst_q <= pfirst_d;
      lhere_q <= lhere_d;
      pend_q <= pend_d;
      mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (oload) begin
      odata_q <= chn_eff;
      oidx_q <= cnt_q[2:0];
      olast_q <= (cnt_q[2:0] == last_idx);
    end
  end

  sha2h_ram #(
    .WIDTH(WORD_W),
    .DEPTH(BLK_DEPTH)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha2h_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CHN_DEPTH)
  ) u_chn_ram (
    .clk_i   (clk_i),
    .we_i    (chn_we),
    .waddr_i (cnt_q[2:0] - 3'd1),
    .wdata_i (chn_eff + wk_a),
    .raddr_i (cnt_q[2:0]),
    .rdata_o (chn_rdata)
  );

  sha2h_core u_core (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .chain_i (chn_eff),
    .blk_i   (blk_rdata),
    .wk_a_o  (wk_a)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = {5'b00000, oidx_q, odata_q};
  assign m_axis_tlast = olast_q;

endmodule

### test/sha256_sha224_hash_test.sv
`timescale 1ns / 100ps

module sha256_sha224_hash_test;
  import sha2h_pkg::*;

  typedef enum bit {
    MODE_SHA256 = 1'b0,
    MODE_SHA224 = 1'b1
  } digest_mode_e;

  typedef struct packed {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_beat_t;

  class digest_scoreboard;
    localparam bit [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam bit [31:0] IV_SHA256 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam bit [31:0] IV_SHA224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    digest_mode_e mode;
    bit [31:0]    hash_state [8];
    bit [31:0]    msg_block [16];
    int unsigned  fill_count;
    bit [63:0]    msg_bits;
    digest_beat_t expected_digest_words [$];
    int unsigned  error_count;
    int unsigned  words_checked;
    int unsigned  digests_predicted;

    function new();
      mode = MODE_SHA256;
      foreach (msg_block[i]) msg_block[i] = '0;
      error_count = 0;
      words_checked = 0;
      digests_predicted = 0;
      restart();
    endfunction

    function void restart();
      foreach (hash_state[i])
        hash_state[i] = (mode == MODE_SHA224) ? IV_SHA224[i] : IV_SHA256[i];
      fill_count = 0;
      msg_bits = '0;
    endfunction

    function void set_mode(digest_mode_e m);
      mode = m;
      restart();
    endfunction

    function bit [31:0] ror(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
        s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
        t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
        s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
        t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function bit put_byte(bit [7:0] value);
      int unsigned pos, sh, idx;
      pos = fill_count & 63;
      idx = pos >> 2;
      sh = 24 - 8 * (pos & 3);
      msg_block[idx] = (msg_block[idx] & ~(32'hff << sh)) | (32'(value) << sh);
      fill_count = pos + 1;
      return fill_count == 64;
    endfunction

    function void note_item(bit [31:0] word, bit [2:0] count, bit eom);
      int unsigned n;
      bit full;
      digest_beat_t beat;
      n = (count > 4) ? 4 : count;
      for (int i = 0; i < n; i++) begin
        msg_bits += 8;
        if (put_byte(8'(word >> (24 - 8 * i)))) begin
          compress();
          fill_count = 0;
        end
      end
      if (!eom) return;
      full = put_byte(8'h80);
      if (full || fill_count > 56) begin
        while (!full) full = put_byte(8'h00);
        compress();
        fill_count = 0;
      end
      while (fill_count < 56) void'(put_byte(8'h00));
      msg_block[14] = msg_bits[63:32];
      msg_block[15] = msg_bits[31:0];
      compress();
      n = (mode == MODE_SHA224) ? 7 : 8;
      for (int i = 0; i < n; i++) begin
        beat.word = hash_state[i];
        beat.index = 3'(i);
        beat.last = (i + 1 == n);
        expected_digest_words.push_back(beat);
      end
      digests_predicted++;
      restart();
    endfunction

    function void check_word(bit [TDATA_W-1:0] data, bit last);
      digest_beat_t exp;
      if (expected_digest_words.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b",
                 $time, data[31:0], data[34:32], last);
        error_count++;
        return;
      end
      exp = expected_digest_words.pop_front();
      words_checked++;
      if (data[31:0] != exp.word) begin
        $display("%0t: digest word %0d expected %h actual %h",
                 $time, exp.index, exp.word, data[31:0]);
        error_count++;
      end
      if (data[34:32] != exp.index) begin
        $display("%0t: word index expected %0d actual %0d", $time, exp.index, data[34:32]);
        error_count++;
      end
      if (last != exp.last) begin
        $display("%0t: last flag at index %0d expected %0b actual %0b",
                 $time, exp.index, exp.last, last);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_digest_words.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  digest_scoreboard hash_sb;
  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct;
  int unsigned      item_count;
  int unsigned      message_count;
  int unsigned      phase_items;

  sha256_sha224_hash DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("sha256_sha224_hash test failed");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) hash_sb.check_word(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_item(bit [31:0] word, bit [2:0] count, bit eom);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, count, word};
    s_axis_tlast <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hash_sb.note_item(word, count, eom);
    item_count++;
    phase_items++;
    if (eom) message_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hash_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(digest_mode_e m);
    drain();
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    hash_sb.set_mode(m);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_message();
    int unsigned body;
    body = ($urandom_range(2) == 0) ? $urandom_range(12, 17) : $urandom_range(0, 33);
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(9) == 0) send_item($urandom, 3'($urandom_range(7)), 1'b0);
      else send_item($urandom, 3'd4, 1'b0);
    end
    send_item($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  initial begin
    hash_sb = new();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    item_count = 0;
    message_count = 0;
    phase_items = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The empty message, then the classic three-byte message.
    send_item(32'h00000000, 3'd0, 1'b1);
    send_item(32'h61626300, 3'd3, 1'b1);
    // All-ones and all-zero words, the second with an oversized byte count.
    send_item(32'hffffffff, 3'd4, 1'b0);
    send_item(32'h00000000, 3'd7, 1'b1);
    // Short and empty items in the middle of a message shift later bytes.
    send_item(32'h11223344, 3'd1, 1'b0);
    send_item(32'haabbccdd, 3'd2, 1'b0);
    send_item(32'h5a5a5a5a, 3'd0, 1'b0);
    send_item(32'h01234567, 3'd4, 1'b0);
    send_item(32'h89abcdef, 3'd5, 1'b1);
    // Fifty-six bytes leave no room for the length, so padding takes a second block.
    for (int i = 0; i < 13; i++) send_item($urandom, 3'd4, 1'b0);
    send_item($urandom, 3'd4, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          write_mode(MODE_SHA224);
          src_idle_pct = 88;
          snk_stall_pct = 0;
        end
        2: begin
          write_mode(MODE_SHA256);
          src_idle_pct = 0;
          snk_stall_pct = 88;
        end
        default: begin
          write_mode(MODE_SHA224);
          src_idle_pct = 27;
          snk_stall_pct = 27;
        end
      endcase
      phase_items = 0;
      send_random_message();
      drain();
      while (phase_items < 20) begin
        send_random_message();
        if ($urandom_range(9) == 0) drain();
      end
      // Leave a partial message behind so the next mode write abandons it.
      for (int i = $urandom_range(20); i > 0; i--) send_item($urandom, 3'd4, 1'b0);
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items in %0d messages over four pacing phases in both modes.",
             item_count, message_count);
    $display("Checked %0d digest words from %0d digests, %0d mismatches.",
             hash_sb.words_checked, hash_sb.digests_predicted, hash_sb.error_count);
    if (hash_sb.error_count == 0 && hash_sb.pending() == 0) begin
      $display("sha256_sha224_hash test passed");
    end else begin
      $display("sha256_sha224_hash test failed");
    end
    $finish;
  end

endmodule
